FILE: rtl/core/chain_centroid_jump_checker_macros.svh
// assertion helpers, clocked on clk_i and held off during reset
`ifndef CHAIN_CENTROID_JUMP_CHECKER_MACROS_SVH
`define CHAIN_CENTROID_JUMP_CHECKER_MACROS_SVH

// same-cycle implication
`define CCJ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ccj_pkg.sv
package ccj_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned SPC_W     = 9;
  localparam int unsigned CC_W      = 8;
  localparam int unsigned HALF_W    = 23;
  localparam int unsigned LIMIT_W   = SPC_W + HALF_W;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned CHNUM_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam int unsigned DEF_MAX_CHAINS = 128;
  localparam int unsigned DEF_MAX_SITES  = 256;

  localparam logic [SPC_W-1:0]  SPC_RESET  = SPC_W'(66);
  localparam logic [CC_W-1:0]   CC_RESET   = CC_W'(100);
  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(7495);

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // result buffer behind the compare stage
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SITES_PER_CHAIN = 2'd0,
    CFG_CHAIN_COUNT     = 2'd1,
    CFG_HALF_BOX        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] site_x;
    logic signed [COORD_W-1:0] site_y;
    logic signed [COORD_W-1:0] site_z;
  } ccj_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [CHNUM_W-1:0] chain_number;
    logic               x_jump;
    logic               y_jump;
    logic               z_jump;
  } ccj_out_t;

  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] z;
  } ccj_sums_t;

endpackage

FILE: rtl/core/chain_centroid_jump_checker.sv
// a chain's result passes stage 1 and stage 2 before it enters the result buffer
// throughput: one site per cycle; stalls only while results back up at the output
// a chain ending right after a chain on the same entry gets the pending sums forwarded
// reset: config returns to 66 sites, 100 chains, half box 7495; frame count to 1
// the history ram is not cleared; the first frame only fills it
module chain_centroid_jump_checker
  import ccj_pkg::*;
#(
  parameter int unsigned MAX_CHAINS = DEF_MAX_CHAINS,
  parameter int unsigned MAX_SITES  = DEF_MAX_SITES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ccj_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ccj_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  `include "chain_centroid_jump_checker_macros.svh"

  localparam int unsigned CHAIN_AW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
  localparam int unsigned SITE_W   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int unsigned SCMP_W   = (SITE_W + 1 > SPC_W) ? SITE_W + 1 : SPC_W;
  localparam int unsigned CCMP_W   = (CHAIN_AW + 1 > CC_W) ? CHAIN_AW + 1 : CC_W;
  localparam int unsigned DIFF_W   = SUM_W + 1;
  localparam int unsigned SUMS_W   = 3 * SUM_W;

  // configuration
  logic [SPC_W-1:0]   spc_q;
  logic [CC_W-1:0]    cc_q;
  logic [HALF_W-1:0]  half_q;
  logic [SPC_W-1:0]   spc_eff;
  logic [CC_W-1:0]    cc_eff;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q  <= SPC_RESET;
      cc_q   <= CC_RESET;
      half_q <= HALF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SITES_PER_CHAIN: spc_q  <= cfg_wdata_i[SPC_W-1:0];
        CFG_CHAIN_COUNT:     cc_q   <= cfg_wdata_i[CC_W-1:0];
        CFG_HALF_BOX:        half_q <= cfg_wdata_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (spc_q == '0) begin
      spc_eff = SPC_W'(1);
    end else if (32'(spc_q) > MAX_SITES) begin
      spc_eff = SPC_W'(MAX_SITES);
    end else begin
      spc_eff = spc_q;
    end
    priority if (cc_q == '0) begin
      cc_eff = CC_W'(1);
    end else if (32'(cc_q) > MAX_CHAINS) begin
      cc_eff = CC_W'(MAX_CHAINS);
    end else begin
      cc_eff = cc_q;
    end
  end

  // threshold on the sum: half box times sites per chain
  always_ff @(posedge clk_i) begin
    limit_q <= LIMIT_W'(half_q) * LIMIT_W'(spc_eff);
  end

  // stage 0: accumulate and count
  logic                 accept;
  logic                 last_site;
  logic [SITE_W-1:0]    site_cnt_q;
  logic [CHAIN_AW-1:0]  chain_cnt_q;
  logic [FRAME_W-1:0]   frame_q;
  ccj_sums_t            acc_q;
  ccj_sums_t            acc_new;

  assign accept    = in_valid_i && !in_stall_o;
  assign last_site = (SCMP_W'(site_cnt_q) + SCMP_W'(1)) >= SCMP_W'(spc_eff);

  always_comb begin
    acc_new.x = acc_q.x + {{(SUM_W-COORD_W){in_data_i.site_x[COORD_W-1]}}, in_data_i.site_x};
    acc_new.y = acc_q.y + {{(SUM_W-COORD_W){in_data_i.site_y[COORD_W-1]}}, in_data_i.site_y};
    acc_new.z = acc_q.z + {{(SUM_W-COORD_W){in_data_i.site_z[COORD_W-1]}}, in_data_i.site_z};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_cnt_q  <= '0;
      chain_cnt_q <= '0;
      frame_q     <= FRAME_W'(1);
      acc_q       <= '0;
    end else if (accept) begin
      if (last_site) begin
        site_cnt_q <= '0;
        acc_q      <= '0;
        if ((CCMP_W'(chain_cnt_q) + CCMP_W'(1)) < CCMP_W'(cc_eff)) begin
          chain_cnt_q <= chain_cnt_q + CHAIN_AW'(1);
        end else begin
          chain_cnt_q <= '0;
          if (frame_q != FRAME_MAX) begin
            frame_q <= frame_q + FRAME_W'(1);
          end
        end
      end else begin
        site_cnt_q <= site_cnt_q + SITE_W'(1);
        acc_q      <= acc_new;
      end
    end
  end

  // history ram: read when a chain closes, written back in the next cycle
  logic               ram_re;
  logic               ram_we;
  logic [SUMS_W-1:0]  ram_rdata;

  // stage 1 registers
  logic                s1_valid_q;
  logic                s1_cmp_q;
  ccj_sums_t           s1_sums_q;
  logic [CHAIN_AW-1:0] s1_chain_q;
  logic [FRAME_W-1:0]  s1_frame_q;
  logic                fwd_q;
  ccj_sums_t           fwd_sums_q;
  ccj_sums_t           old_sums;

  assign ram_re = accept && last_site;
  assign ram_we = s1_valid_q;

  ccj_ram #(
    .WIDTH (SUMS_W),
    .DEPTH (MAX_CHAINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_chain_q),
    .wdata_i (s1_sums_q),
    .re_i    (ram_re),
    .raddr_i (chain_cnt_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= ram_re;
      // read and write of the same entry collide: take the sums being written
      fwd_q      <= ram_re && ram_we && (chain_cnt_q == s1_chain_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_sums_q  <= acc_new;
      s1_chain_q <= chain_cnt_q;
      s1_frame_q <= frame_q;
      s1_cmp_q   <= frame_q > FRAME_W'(1);
    end
    fwd_sums_q <= s1_sums_q;
  end

  assign old_sums = fwd_q ? fwd_sums_q : ccj_sums_t'(ram_rdata);

  // stage 2: differences, compared on the way into the result buffer
  logic                s2_valid_q;
  logic [DIFF_W-1:0]   s2_dx_q;
  logic [DIFF_W-1:0]   s2_dy_q;
  logic [DIFF_W-1:0]   s2_dz_q;
  logic [CHAIN_AW-1:0] s2_chain_q;
  logic [FRAME_W-1:0]  s2_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_cmp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_dx_q    <= {s1_sums_q.x[SUM_W-1], s1_sums_q.x} - {old_sums.x[SUM_W-1], old_sums.x};
      s2_dy_q    <= {s1_sums_q.y[SUM_W-1], s1_sums_q.y} - {old_sums.y[SUM_W-1], old_sums.y};
      s2_dz_q    <= {s1_sums_q.z[SUM_W-1], s1_sums_q.z} - {old_sums.z[SUM_W-1], old_sums.z};
      s2_chain_q <= s1_chain_q;
      s2_frame_q <= s1_frame_q;
    end
  end

  logic signed [DIFF_W:0] lim_pos;
  logic signed [DIFF_W:0] lim_neg;
  logic signed [DIFF_W:0] dx_e;
  logic signed [DIFF_W:0] dy_e;
  logic signed [DIFF_W:0] dz_e;
  ccj_out_t               res;
  logic                   push;

  always_comb begin
    lim_pos = $signed({{(DIFF_W+1-LIMIT_W){1'b0}}, limit_q});
    lim_neg = -lim_pos;
    dx_e    = $signed({s2_dx_q[DIFF_W-1], s2_dx_q});
    dy_e    = $signed({s2_dy_q[DIFF_W-1], s2_dy_q});
    dz_e    = $signed({s2_dz_q[DIFF_W-1], s2_dz_q});
    res.frame_number = s2_frame_q;
    res.chain_number = CHNUM_W'(CCMP_W'(s2_chain_q) + CCMP_W'(1));
    res.x_jump = (dx_e > lim_pos) || (dx_e < lim_neg);
    res.y_jump = (dy_e > lim_pos) || (dy_e < lim_neg);
    res.z_jump = (dz_e > lim_pos) || (dz_e < lim_neg);
  end

  assign push = s2_valid_q && (res.x_jump || res.y_jump || res.z_jump);

  // result buffer; input is held off while it could overflow
  ccj_out_t             buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic [OUT_CNT_W-1:0] pending;
  logic                 pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = buf_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign pending     = cnt_q + OUT_CNT_W'(s1_valid_q && s1_cmp_q) + OUT_CNT_W'(s2_valid_q);
  assign in_stall_o  = pending >= OUT_CNT_W'(OUT_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  `CCJ_ASSERT_IMPL(a_credit_bound, 1'b1, pending <= OUT_CNT_W'(OUT_DEPTH), "result buffer overcommitted")
  `CCJ_ASSERT_NEXT(a_fwd_source, ram_re && ram_we && (chain_cnt_q == s1_chain_q), fwd_q, "missed forward")
  `CCJ_ASSERT_IMPL(a_out_has_jump, out_valid_o, out_data_o.x_jump || out_data_o.y_jump || out_data_o.z_jump, "result without jump")
  `CCJ_ASSERT_IMPL(a_out_frame, out_valid_o, out_data_o.frame_number != FRAME_W'(1), "result in first frame")

endmodule

FILE: rtl/core/ccj_ram.sv
module ccj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
